[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, codes and helpers for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int CNT_W     = 11;  // block numbers and free count
    localparam int STAT_W    = 2;
    localparam int WORD_BITS = 32;
    localparam int POS_W     = 5;   // bit position inside a word

    // request function codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_USED  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE_ERR = 2'd3;

    localparam logic [WORD_BITS-1:0] TOP_BIT = 32'h8000_0000;

    // Position of the first clear bit, counting from the MSB. Caller
    // guarantees at least one clear bit.
    function automatic logic [POS_W-1:0] first_zero_msb(input logic [WORD_BITS-1:0] w);
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[WORD_BITS-1-i]) begin
                pos = POS_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

[rtl/bba_req_if.sv]
// ----------------------------------------------------------------------------
// bba_req_if
// Request channel: function code and 1-based block number.
// ----------------------------------------------------------------------------
interface bba_req_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [bba_pkg::CNT_W-1:0]  block_number;

    modport source (output valid, output func, output block_number, input ready);
    modport sink   (input valid, input func, input block_number, output ready);
endinterface

[rtl/bba_rsp_if.sv]
// ----------------------------------------------------------------------------
// bba_rsp_if
// Response channel: allocated number, status and free block count.
// ----------------------------------------------------------------------------
interface bba_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [bba_pkg::CNT_W-1:0]  allocated_number;
    logic [bba_pkg::STAT_W-1:0] status;
    logic [bba_pkg::CNT_W-1:0]  free_count;

    modport source (output valid, output allocated_number, output status,
                    output free_count, input ready);
    modport sink   (input valid, input allocated_number, input status,
                    input free_count, output ready);
endinterface

[rtl/bitmap_block_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Free-list allocator over a usage bitmap of NUM_WORDS x 32 blocks.
// ----------------------------------------------------------------------------
// Usage:
//   i_req  : request channel (valid/ready). func = alloc gives out the lowest
//            free block; func = free releases the 1-based block_number.
//   o_rsp  : one response per request: allocated number (0 on free or when
//            full), status and the free block count after the request.
//   Timing : the accepting edge reads the bitmap word, the modify state
//            writes it back and the reply state loads the response; no
//            new request is accepted until the response is loaded
//            (single-port memory, one request in flight). Range errors and
//            a full bitmap skip the modify state and its write-back.
//   Stall  : the response sits in an output register. If the receiver holds
//            ready low, the block finishes the next request and waits in
//            its reply state until the output register frees up; no
//            request is accepted meanwhile.
//   Reset  : synchronous, active low. Per-word valid flags clear at once, so
//            every block reads as free with no clearing pass; the free count
//            returns to NUM_WORDS x 32 and the word-full flags clear.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
    parameter int NUM_WORDS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bba_req_if.sink    i_req,
    bba_rsp_if.source  o_rsp
);
    import bba_pkg::*;

    localparam int IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(NUM_WORDS * WORD_BITS);

    typedef enum logic [1:0] {S_IDLE, S_MODIFY, S_REPLY} t_state;

    // bitmap store; bit (31 - s) of a word is block s of that word
    logic [WORD_BITS-1:0] mem_usage [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;

    t_state               r_state;
    logic [NUM_WORDS-1:0] r_word_vld;   // word written since reset
    logic [NUM_WORDS-1:0] r_word_full;
    logic [CNT_W-1:0]     r_free_cnt;
    logic                 r_func;
    logic [IDX_W-1:0]     r_idx;
    logic [POS_W-1:0]     r_pos;        // bit position for a free
    logic                 r_rd_vld;
    logic [CNT_W-1:0]     r_res_alloc;
    logic [STAT_W-1:0]    r_res_status;

    logic                 r_out_valid;
    logic [CNT_W-1:0]     r_out_alloc;
    logic [STAT_W-1:0]    r_out_status;
    logic [CNT_W-1:0]     r_out_free;

    // ---- request decode (idle) ----
    logic                 req_fire;
    logic                 alloc_found;
    logic [IDX_W-1:0]     alloc_idx;
    logic [CNT_W-1:0]     num_m1;
    logic                 range_bad;
    logic [IDX_W-1:0]     rd_idx;
    logic                 out_load;

    assign req_fire = i_req.valid && i_req.ready;

    // lowest word that still has a free block
    always_comb begin
        alloc_found = 1'b0;
        alloc_idx   = '0;
        for (int v = NUM_WORDS - 1; v >= 0; v--) begin
            if (!r_word_full[v]) begin
                alloc_found = 1'b1;
                alloc_idx   = IDX_W'(v);
            end
        end
    end

    assign num_m1    = i_req.block_number - CNT_W'(1);
    assign range_bad = (i_req.block_number == '0) || (i_req.block_number > CAPACITY);
    assign rd_idx    = (i_req.func == FUNC_ALLOC) ? alloc_idx
                                                  : IDX_W'(num_m1[CNT_W-1:POS_W]);

    // response register loads when it is empty or being drained
    assign out_load  = (r_state == S_REPLY) && (!r_out_valid || o_rsp.ready);

    // ---- modify (in the cycle after the read) ----
    logic [WORD_BITS-1:0] cur_word;
    logic [POS_W-1:0]     alloc_pos;
    logic [POS_W-1:0]     n_pos;
    logic [WORD_BITS-1:0] n_mask;
    logic                 n_in_use;
    logic [WORD_BITS-1:0] n_word;
    logic                 wr_en;

    assign cur_word  = r_rd_vld ? r_rd_data : '0;   // unwritten word is all free
    assign alloc_pos = first_zero_msb(cur_word);
    assign n_pos     = (r_func == FUNC_ALLOC) ? alloc_pos : r_pos;
    assign n_mask    = TOP_BIT >> n_pos;
    assign n_in_use  = |(cur_word & n_mask);
    assign n_word    = (r_func == FUNC_ALLOC) ? (cur_word | n_mask) : (cur_word & ~n_mask);
    assign wr_en     = (r_state == S_MODIFY) && ((r_func == FUNC_ALLOC) || n_in_use);

    // memory: registered read on acceptance, write back in the modify cycle
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_rd_data <= mem_usage[rd_idx];
        end
        if (wr_en) begin
            mem_usage[r_idx] <= n_word;
        end
    end

    // ---- control, counters and output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_word_vld   <= '0;
            r_word_full  <= '0;
            r_free_cnt   <= CAPACITY;
            r_out_valid  <= 1'b0;
            r_func       <= FUNC_ALLOC;
            r_idx        <= '0;
            r_pos        <= '0;
            r_rd_vld     <= 1'b0;
            r_res_alloc  <= '0;
            r_res_status <= ST_OK;
            r_out_alloc  <= '0;
            r_out_status <= ST_OK;
            r_out_free   <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        r_func      <= i_req.func;
                        r_idx       <= rd_idx;
                        r_pos       <= num_m1[POS_W-1:0];
                        r_rd_vld    <= r_word_vld[rd_idx];
                        r_res_alloc <= '0;
                        if (i_req.func == FUNC_ALLOC && !alloc_found) begin
                            r_res_status <= ST_FULL;
                            r_state      <= S_REPLY;
                        end else if (i_req.func == FUNC_FREE && range_bad) begin
                            r_res_status <= ST_RANGE_ERR;
                            r_state      <= S_REPLY;
                        end else begin
                            r_res_status <= ST_OK;
                            r_state      <= S_MODIFY;
                        end
                    end
                end

                S_MODIFY: begin
                    if (r_func == FUNC_ALLOC) begin
                        r_word_vld[r_idx]  <= 1'b1;
                        r_word_full[r_idx] <= &n_word;
                        r_free_cnt         <= r_free_cnt - CNT_W'(1);
                        r_res_alloc        <= CNT_W'({r_idx, alloc_pos}) + CNT_W'(1);
                    end else if (n_in_use) begin
                        r_word_vld[r_idx]  <= 1'b1;
                        r_word_full[r_idx] <= 1'b0;
                        r_free_cnt         <= r_free_cnt + CNT_W'(1);
                    end else begin
                        r_res_status       <= ST_NOT_USED;
                    end
                    r_state <= S_REPLY;
                end

                S_REPLY: begin
                    if (out_load) begin
                        r_out_alloc  <= r_res_alloc;
                        r_out_status <= r_res_status;
                        r_out_free   <= r_free_cnt;
                        r_state      <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready            = (r_state == S_IDLE);
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.allocated_number = r_out_alloc;
    assign o_rsp.status           = r_out_status;
    assign o_rsp.free_count       = r_out_free;

    // ---- assertions ----
    a_free_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= CAPACITY)
        else $error("free count above capacity");

    a_err_no_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.allocated_number == '0))
        else $error("number given out on a failed request");

    a_full_flags_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_word_full) |-> (r_free_cnt == '0))
        else $error("all words flagged full with free blocks left");

    a_accept_to_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> !i_req.ready)
        else $error("new request taken while one is in progress");

endmodule

[bench/bitmap_block_allocator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_tb
// Drives allocate and release requests into the bitmap block allocator, runs
// a bit-level prediction of the usage bitmap alongside it and checks every
// response in order. A short directed table comes first, followed by random
// traffic that fills the bitmap, runs into the full condition and churns
// around it. Both channels idle in random bursts except near the end.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_tb;
    import bba_pkg::*;

    localparam int NUM_WORDS   = 32;
    localparam int NUM_BLOCKS  = NUM_WORDS * WORD_BITS;
    localparam int HALF_PERIOD = 6;
    localparam int CHURN_ITEMS = 24;

    // one response as seen on the output channel
    typedef struct packed {
        logic [CNT_W-1:0]  number;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  free_cnt;
    } grant_t;

    // directed stimulus: typed rows carry a hand-written answer
    typedef struct {
        logic             func;
        logic [CNT_W-1:0] num;
        bit               typed;
        grant_t           want;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;

    bba_req_if req_bus ();
    bba_rsp_if rsp_bus ();

    bitmap_block_allocator #(
        .NUM_WORDS (NUM_WORDS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // ------------------------------------------------------------------------
    // Shadow of the allocator state. A set bit marks a block in use; within
    // each word the most significant bit is the lowest block number.
    // ------------------------------------------------------------------------
    logic [WORD_BITS-1:0] used_map [NUM_WORDS];
    logic [CNT_W-1:0]     free_left;
    logic [WORD_BITS-1:0] full_words;

    grant_t pending_grants [$];
    int     mismatches;
    bit     calm;       // no idling on either side once set

    stim_row_t directed_rows [15];

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // The slowest legal run (about 1.1k requests, each with an idle gap, its
    // processing and a response stall) ends well inside this limit.
    initial begin
        #5_000_000;
        $display("bitmap_block_allocator verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor: applies one request to the shadow state and returns the
    // response the block should give.
    // ------------------------------------------------------------------------
    function automatic grant_t predict_grant(input logic func,
                                             input logic [CNT_W-1:0] num);
        grant_t g;
        int     w;
        int     b;
        bit     found;
        g       = '0;
        g.status = ST_OK;
        found   = 1'b0;
        if (func == FUNC_ALLOC) begin
            // first free bit, word by word, MSB first; full words are skipped
            for (w = 0; w < NUM_WORDS && !found; w++) begin
                if (!full_words[w]) begin
                    for (b = 0; b < WORD_BITS && !found; b++) begin
                        if (!used_map[w][WORD_BITS-1-b]) begin
                            used_map[w][WORD_BITS-1-b] = 1'b1;
                            if (&used_map[w])
                                full_words[w] = 1'b1;
                            if (free_left != 0)
                                free_left = free_left - 1'b1;
                            g.number = CNT_W'(w * WORD_BITS + b + 1);
                            found    = 1'b1;
                        end
                    end
                end
            end
            if (!found)
                g.status = ST_FULL;
        end else begin
            if (num == 0 || num > NUM_BLOCKS) begin
                g.status = ST_RANGE_ERR;
            end else begin
                w = (num - 1) / WORD_BITS;
                b = (num - 1) % WORD_BITS;
                if (!used_map[w][WORD_BITS-1-b]) begin
                    g.status = ST_NOT_USED;
                end else begin
                    used_map[w][WORD_BITS-1-b] = 1'b0;
                    full_words[w]              = 1'b0;
                    if (free_left < NUM_BLOCKS)
                        free_left = free_left + 1'b1;
                end
            end
        end
        g.free_cnt = free_left;
        return g;
    endfunction

    // Random block that is currently in use; caller makes sure one exists.
    function automatic logic [CNT_W-1:0] pick_used_block();
        int n;
        n = $urandom_range(1, NUM_BLOCKS);
        while (!used_map[(n - 1) / WORD_BITS][WORD_BITS-1-((n - 1) % WORD_BITS)])
            n = (n == NUM_BLOCKS) ? 1 : n + 1;
        return CNT_W'(n);
    endfunction

    task automatic report_mismatch(input string what, input grant_t want, input grant_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected num=%0d st=%0d free=%0d, got num=%0d st=%0d free=%0d",
                     $realtime, what, want.number, want.status, want.free_cnt,
                     got.number, got.status, got.free_cnt);
    endtask

    // ------------------------------------------------------------------------
    // Request driver. Called at a falling edge; returns at a falling edge
    // after the request has been taken. An optional idle burst goes first.
    // Typed rows queue their hand-written answer, but the shadow state is
    // updated either way so later predictions stay in step.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic func, input logic [CNT_W-1:0] num,
                                input bit typed, input grant_t typed_want);
        grant_t g;
        int     gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.func         <= func;
        req_bus.block_number <= num;
        do @(posedge i_clk); while (!req_bus.ready);
        g = predict_grant(func, num);
        pending_grants.push_back(typed ? typed_want : g);
        @(negedge i_clk);
    endtask

    task automatic send_noise();
        send_request(logic'($urandom_range(0, 1)), CNT_W'($urandom_range(0, 2047)),
                     1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Response side: random stall bursts on ready, checked at the rising edge
    // ------------------------------------------------------------------------
    int stall_left;

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
        end else if (!calm && i_rst_n && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        grant_t got;
        grant_t want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            got.number   = rsp_bus.allocated_number;
            got.status   = rsp_bus.status;
            got.free_cnt = rsp_bus.free_count;
            if (pending_grants.size() == 0) begin
                report_mismatch("response with no request outstanding", '0, got);
            end else begin
                want = pending_grants.pop_front();
                if (got.number !== want.number || got.status !== want.status ||
                    got.free_cnt !== want.free_cnt)
                    report_mismatch("response mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int r;
        i_rst_n              = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.func         = FUNC_ALLOC;
        req_bus.block_number = '0;
        rsp_bus.ready        = 1'b0;
        stall_left           = 0;
        mismatches           = 0;
        calm                 = 1'b0;
        for (int w = 0; w < NUM_WORDS; w++)
            used_map[w] = '0;
        free_left  = CNT_W'(NUM_BLOCKS);
        full_words = '0;

        // Directed rows. After reset every block is free (count 1024).
        directed_rows = '{
            // release of block zero and of numbers past the end
            '{FUNC_FREE,  11'd0,    1'b1, '{11'd0, ST_RANGE_ERR, 11'd1024}},
            '{FUNC_FREE,  11'd1025, 1'b1, '{11'd0, ST_RANGE_ERR, 11'd1024}},
            '{FUNC_FREE,  11'd2047, 1'b1, '{11'd0, ST_RANGE_ERR, 11'd1024}},
            // release of blocks never handed out, at both ends of the map
            '{FUNC_FREE,  11'd1,    1'b1, '{11'd0, ST_NOT_USED,  11'd1024}},
            '{FUNC_FREE,  11'd1024, 1'b1, '{11'd0, ST_NOT_USED,  11'd1024}},
            // allocations ignore block_number
            '{FUNC_ALLOC, 11'd2047, 1'b1, '{11'd1, ST_OK,        11'd1023}},
            '{FUNC_ALLOC, 11'd0,    1'b1, '{11'd2, ST_OK,        11'd1022}},
            '{FUNC_ALLOC, 11'd1365, 1'b1, '{11'd3, ST_OK,        11'd1021}},
            // hole in the middle is handed out again first
            '{FUNC_FREE,  11'd2,    1'b1, '{11'd0, ST_OK,        11'd1022}},
            '{FUNC_ALLOC, 11'd682,  1'b1, '{11'd2, ST_OK,        11'd1021}},
            '{FUNC_FREE,  11'd3,    1'b0, '{11'd0, ST_OK,        11'd0}},
            '{FUNC_FREE,  11'd3,    1'b0, '{11'd0, ST_OK,        11'd0}},
            '{FUNC_ALLOC, 11'd1024, 1'b0, '{11'd0, ST_OK,        11'd0}},
            '{FUNC_FREE,  11'd33,   1'b0, '{11'd0, ST_OK,        11'd0}},
            '{FUNC_FREE,  11'd1040, 1'b0, '{11'd0, ST_OK,        11'd0}}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].func, directed_rows[i].num,
                         directed_rows[i].typed, directed_rows[i].want);

        // Fill the map, with the odd release punching holes that the search
        // has to find again, and some junk requests mixed in.
        while (free_left != 0) begin
            r = $urandom_range(0, 99);
            if (r < 98)
                send_request(FUNC_ALLOC, CNT_W'($urandom_range(0, 2047)), 1'b0, '0);
            else if (r < 99 && free_left < NUM_BLOCKS)
                send_request(FUNC_FREE, pick_used_block(), 1'b0, '0);
            else
                send_noise();
        end

        // map is full now: allocations must be refused
        repeat (3)
            send_request(FUNC_ALLOC, CNT_W'($urandom_range(0, 2047)), 1'b0, '0);

        // churn around the full point; the tail runs without idling
        for (int i = 0; i < CHURN_ITEMS; i++) begin
            if (i == CHURN_ITEMS / 2)
                calm = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 45)
                send_request(FUNC_ALLOC, '0, 1'b0, '0);
            else if (r < 90 && free_left < NUM_BLOCKS)
                send_request(FUNC_FREE, pick_used_block(), 1'b0, '0);
            else
                send_noise();
        end
        req_bus.valid <= 1'b0;

        while (pending_grants.size() != 0)
            @(posedge i_clk);
        // keep the clock running to catch any stray response
        repeat (12) @(posedge i_clk);

        if (pending_grants.size() != 0)
            report_mismatch("request left without a response", pending_grants[0], '0);

        if (mismatches == 0) begin
            $display("bitmap_block_allocator verification clean");
        end else begin
            $display("bitmap_block_allocator verification failed");
        end
        $finish;
    end

endmodule

[bitmap_block_allocator.f]
rtl/bba_pkg.sv
rtl/bba_req_if.sv
rtl/bba_rsp_if.sv
rtl/bitmap_block_allocator.sv
bench/bitmap_block_allocator_tb.sv
